>>> design/eers_pkg.sv
package eers_pkg;

  localparam int MAX_SCORES_DEF = 1024;
  localparam int RATE_FRAC_DEF  = 16;

  localparam int SCORE_W   = 21;
  localparam int THR_W     = 17;
  localparam int NT_W      = THR_W + 1;
  localparam int OUT_W     = 17;
  localparam int TOTAL_W   = 11;
  localparam int CFG_IDX_W = 1;

  // one histogram bin per saturated score value -1 .. 100001
  localparam int HIST_DEPTH = 100003;
  localparam int HIST_AW    = $clog2(HIST_DEPTH);

  localparam logic [HIST_AW-1:0]        HIST_LAST  = HIST_AW'(HIST_DEPTH - 1);
  localparam logic signed [SCORE_W:0]   IDX_TOP    = (SCORE_W + 1)'(HIST_DEPTH - 1);
  localparam logic signed [SCORE_W:0]   IDX_ONE    = (SCORE_W + 1)'(1);
  localparam logic [THR_W-1:0]          THRESH_CAP = THR_W'(100000);
  localparam logic [THR_W-1:0]          STEP_RESET = THR_W'(1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP = 1'b0,
    CFG_MAX  = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic             start;
    logic             valid;
    logic [THR_W-1:0] thr;
  } eval_cmd_t;

endpackage

>>> design/eers_hist_ram.sv
module eers_hist_ram #(
  parameter int DW    = 22,
  parameter int DEPTH = eers_pkg::HIST_DEPTH,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/eers_divider.sv
module eers_divider #(
  parameter int NW = 23,
  parameter int F  = eers_pkg::RATE_FRAC_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [NW-1:0] den_i,
  output logic          done_o,
  output logic [F:0]    quot_o
);

  localparam int XW   = NW + F + 1;
  localparam int QW   = F + 1;
  localparam int CNTW = $clog2(QW);

  logic [XW-1:0]   x_q, d_q;
  logic [QW-1:0]   q_q;
  logic [CNTW-1:0] cnt_q;
  logic            busy_q, done_q, zero_q;
  logic            ge;

  assign ge = x_q >= d_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // quotient is below 2^(F+1), so only F+1 restoring steps are needed
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= (XW'(num_i) << F) + XW'(den_i >> 1);
      d_q    <= XW'(den_i) << F;
      q_q    <= '0;
      cnt_q  <= CNTW'(QW - 1);
      zero_q <= den_i == '0;
    end else if (busy_q) begin
      if (ge) begin
        x_q <= x_q - d_q;
      end
      q_q   <= {q_q[QW-2:0], ge};
      d_q   <= d_q >> 1;
      cnt_q <= cnt_q - CNTW'(1);
    end
  end

  assign done_o = done_q;
  assign quot_o = zero_q ? '0 : q_q;

endmodule

>>> design/eers_best_track.sv
module eers_best_track #(
  parameter int CW = $clog2(eers_pkg::MAX_SCORES_DEF + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  eers_pkg::eval_cmd_t           cmd_i,
  input  logic [CW-1:0]                 below_imp_i,
  input  logic [CW-1:0]                 below_gen_i,
  input  logic [CW-1:0]                 imp_total_i,
  input  logic [CW-1:0]                 gen_total_i,
  output logic                          busy_o,
  output logic [eers_pkg::THR_W-1:0]    best_t_o,
  output logic [CW-1:0]                 best_fa_o,
  output logic [CW-1:0]                 best_fr_o,
  output logic [2*CW-1:0]               best_a_o,
  output logic [2*CW-1:0]               best_b_o
);

  import eers_pkg::*;

  localparam int PW = 2 * CW;

  logic [CW-1:0]    gen_d, imp_d, fa, fr;
  logic [PW-1:0]    a_prod, b_prod, diff;
  logic             e1_valid_q, have_q;
  logic [THR_W-1:0] e1_t_q, best_t_q;
  logic [CW-1:0]    e1_fa_q, e1_fr_q, best_fa_q, best_fr_q;
  logic [PW-1:0]    e1_a_q, e1_b_q, best_a_q, best_b_q, best_diff_q;
  logic             take;

  always_comb begin
    gen_d  = (gen_total_i == '0) ? CW'(1) : gen_total_i;
    imp_d  = (imp_total_i == '0) ? CW'(1) : imp_total_i;
    fa     = (imp_total_i == '0) ? '0 : imp_total_i - below_imp_i;
    fr     = (gen_total_i == '0) ? '0 : below_gen_i;
    a_prod = PW'(fa) * PW'(gen_d);
    b_prod = PW'(fr) * PW'(imp_d);
    diff   = (e1_a_q > e1_b_q) ? e1_a_q - e1_b_q : e1_b_q - e1_a_q;
    // strict compare keeps the first threshold on ties
    take   = e1_valid_q && (!have_q || diff < best_diff_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e1_valid_q <= 1'b0;
      have_q     <= 1'b0;
    end else begin
      e1_valid_q <= cmd_i.valid;
      if (cmd_i.start) begin
        have_q <= 1'b0;
      end else if (take) begin
        have_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.valid) begin
      e1_t_q  <= cmd_i.thr;
      e1_fa_q <= fa;
      e1_fr_q <= fr;
      e1_a_q  <= a_prod;
      e1_b_q  <= b_prod;
    end
    if (take) begin
      best_diff_q <= diff;
      best_t_q    <= e1_t_q;
      best_fa_q   <= e1_fa_q;
      best_fr_q   <= e1_fr_q;
      best_a_q    <= e1_a_q;
      best_b_q    <= e1_b_q;
    end
  end

  assign busy_o    = e1_valid_q;
  assign best_t_o  = best_t_q;
  assign best_fa_o = best_fa_q;
  assign best_fr_o = best_fr_q;
  assign best_a_o  = best_a_q;
  assign best_b_o  = best_b_q;

endmodule

>>> design/equal_error_rate_sweep.sv
// Channel  Direction  Handshake              Word
// in       input      in_valid/in_ready      score_milli, genuine, last_item
// cfg      input      cfg_valid/cfg_ready    cfg_index, cfg_data (17 bits)
// out      output     out_valid/out_ready    eer, threshold, far, frr, totals, overflowed
//
// Scores load at one word per cycle as read-modify-write of a 100003-bin histogram RAM.
// After the last word a drain state leads into the sweep, which walks every bin once and
// clears it behind; a flush state lets the pipeline empty, then three serial divisions
// share one divider (FAR, FRR, EER) and an emit state hands the result on.
// After reset a clearing pass over every bin runs before in_ready rises; cfg is
// always ready. A result held by out_ready low stalls only the next set's finish.
module equal_error_rate_sweep #(
  parameter int MAX_SCORES         = eers_pkg::MAX_SCORES_DEF,
  parameter int RATE_FRACTION_BITS = eers_pkg::RATE_FRAC_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,

  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [eers_pkg::SCORE_W-1:0] score_milli_i,
  input  logic                               genuine_i,
  input  logic                               last_item_i,

  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [eers_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [eers_pkg::THR_W-1:0]         cfg_data_i,

  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [eers_pkg::OUT_W-1:0]         eer_q16_o,
  output logic [eers_pkg::THR_W-1:0]         best_threshold_milli_o,
  output logic [eers_pkg::OUT_W-1:0]         far_q16_o,
  output logic [eers_pkg::OUT_W-1:0]         frr_q16_o,
  output logic [eers_pkg::TOTAL_W-1:0]       genuine_total_o,
  output logic [eers_pkg::TOTAL_W-1:0]       impostor_total_o,
  output logic                               overflowed_o
);

  import eers_pkg::*;

  localparam int CW = $clog2(MAX_SCORES + 1);
  localparam int PW = 2 * CW;
  localparam int NW = PW + 1;
  localparam int EW = 2 * CW;
  localparam int QW = RATE_FRACTION_BITS + 1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_LOAD,
    ST_DRAIN,
    ST_SWEEP,
    ST_FLUSH,
    ST_DIV_FAR,
    ST_DIV_FRR,
    ST_DIV_EER,
    ST_EMIT
  } state_e;

  state_e             state_q;
  logic [THR_W-1:0]   step_q, tmax_q, step_eff, tmax_eff;
  logic [CW-1:0]      stored_q, gen_q, imp_cnt, imp_d, gen_d;
  logic               ovf_q;
  logic [HIST_AW-1:0] p_q;

  logic               in_acc, store;
  logic signed [SCORE_W:0] sp1;
  logic [HIST_AW-1:0] ld_idx;

  logic               ram_we, ram_re;
  logic [HIST_AW-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0]      ram_wdata, ram_rdata, base;

  logic               ld1_valid_q, ld1_gen_q;
  logic [HIST_AW-1:0] ld1_addr_q;
  logic               wr_valid_q;
  logic [HIST_AW-1:0] wr_addr_q;
  logic [EW-1:0]      wr_data_q;

  logic               sw1_valid_q, ev_q, hit;
  logic [HIST_AW-1:0] sw1_p_q;
  logic [THR_W-1:0]   ev_t_q;
  logic [NT_W-1:0]    nt_q;
  logic [CW-1:0]      below_imp_q, below_gen_q;
  logic [PW-1:0]      dprod_q;

  eval_cmd_t          cmd;
  logic               trk_busy;
  logic [THR_W-1:0]   best_t;
  logic [CW-1:0]      best_fa, best_fr;
  logic [PW-1:0]      best_a, best_b;

  logic               div_start_q, div_done;
  logic [NW-1:0]      div_num, div_den;
  logic [QW-1:0]      div_quot, far_q, frr_q, eer_q;

  logic               out_valid_q, emit;
  logic [OUT_W-1:0]   res_eer_q, res_far_q, res_frr_q;
  logic [THR_W-1:0]   res_t_q;
  logic [TOTAL_W-1:0] res_gen_q, res_imp_q;
  logic               res_ovf_q;

  // ---------------------------------------------------------------- config
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_RESET;
      tmax_q <= THRESH_CAP;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_STEP: step_q <= cfg_data_i;
        CFG_MAX:  tmax_q <= cfg_data_i;
        default:  ;
      endcase
    end
  end

  assign step_eff = (step_q == '0) ? THR_W'(1) : step_q;
  assign tmax_eff = (tmax_q > THRESH_CAP) ? THRESH_CAP : tmax_q;

  // ---------------------------------------------------------------- input
  assign in_ready_o = state_q == ST_LOAD;
  assign in_acc     = in_valid_i && in_ready_o;
  assign store      = in_acc && (stored_q < CW'(MAX_SCORES));
  assign imp_cnt    = stored_q - gen_q;
  assign imp_d      = (imp_cnt == '0) ? CW'(1) : imp_cnt;
  assign gen_d      = (gen_q == '0) ? CW'(1) : gen_q;

  // saturate to -1 .. 100001, then offset by one to get the bin
  always_comb begin
    sp1 = (SCORE_W + 1)'(score_milli_i) + IDX_ONE;
    if (sp1[SCORE_W]) begin
      ld_idx = '0;
    end else if (sp1 > IDX_TOP) begin
      ld_idx = HIST_LAST;
    end else begin
      ld_idx = sp1[HIST_AW-1:0];
    end
  end

  // ---------------------------------------------------------------- histogram RAM
  assign ram_re    = store || (state_q == ST_SWEEP);
  assign ram_raddr = (state_q == ST_SWEEP) ? p_q : ld_idx;

  // forward the write that landed on the same edge as this read
  assign base = (wr_valid_q && wr_addr_q == ld1_addr_q) ? wr_data_q : ram_rdata;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = p_q;
    ram_wdata = '0;
    priority if (state_q == ST_CLEAR) begin
      ram_we = 1'b1;
    end else if (ld1_valid_q) begin
      ram_we    = 1'b1;
      ram_waddr = ld1_addr_q;
      if (ld1_gen_q) begin
        ram_wdata = {base[EW-1:CW] + CW'(1), base[CW-1:0]};
      end else begin
        ram_wdata = {base[EW-1:CW], base[CW-1:0] + CW'(1)};
      end
    end else if (sw1_valid_q) begin
      // drop the bin once it is counted
      ram_we    = 1'b1;
      ram_waddr = sw1_p_q;
    end else begin
      ram_we = 1'b0;
    end
  end

  eers_hist_ram #(
    .DW    (EW),
    .DEPTH (HIST_DEPTH)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------- sweep datapath
  assign hit = sw1_valid_q && (NT_W'(sw1_p_q) == nt_q) && (nt_q <= NT_W'(tmax_eff));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ld1_valid_q <= 1'b0;
      wr_valid_q  <= 1'b0;
      sw1_valid_q <= 1'b0;
      ev_q        <= 1'b0;
    end else begin
      ld1_valid_q <= store;
      wr_valid_q  <= ram_we;
      sw1_valid_q <= state_q == ST_SWEEP;
      ev_q        <= hit;
    end
  end

  always_ff @(posedge clk_i) begin
    ld1_addr_q <= ld_idx;
    ld1_gen_q  <= genuine_i;
    wr_addr_q  <= ram_waddr;
    wr_data_q  <= ram_wdata;
    sw1_p_q    <= p_q;
    dprod_q    <= PW'(imp_d) * PW'(gen_d);
    if (state_q == ST_DRAIN) begin
      below_imp_q <= '0;
      below_gen_q <= '0;
      nt_q        <= '0;
    end else begin
      if (sw1_valid_q) begin
        below_imp_q <= below_imp_q + ram_rdata[CW-1:0];
        below_gen_q <= below_gen_q + ram_rdata[EW-1:CW];
      end
      if (hit) begin
        nt_q   <= nt_q + NT_W'(step_eff);
        ev_t_q <= sw1_p_q[THR_W-1:0];
      end
    end
  end

  always_comb begin
    cmd.start = state_q == ST_DRAIN;
    cmd.valid = ev_q;
    cmd.thr   = ev_t_q;
  end

  eers_best_track #(
    .CW (CW)
  ) u_best_track (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .below_imp_i (below_imp_q),
    .below_gen_i (below_gen_q),
    .imp_total_i (imp_cnt),
    .gen_total_i (gen_q),
    .busy_o      (trk_busy),
    .best_t_o    (best_t),
    .best_fa_o   (best_fa),
    .best_fr_o   (best_fr),
    .best_a_o    (best_a),
    .best_b_o    (best_b)
  );

  // ---------------------------------------------------------------- divisions
  always_comb begin
    unique case (state_q)
      ST_DIV_FRR: begin
        div_num = NW'(best_fr);
        div_den = NW'(gen_q);
      end
      ST_DIV_EER: begin
        div_num = NW'(best_a) + NW'(best_b);
        div_den = {dprod_q, 1'b0};
      end
      default: begin
        div_num = NW'(best_fa);
        div_den = NW'(imp_cnt);
      end
    endcase
  end

  eers_divider #(
    .NW (NW),
    .F  (RATE_FRACTION_BITS)
  ) u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start_q),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // ---------------------------------------------------------------- control
  assign emit = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      p_q         <= '0;
      stored_q    <= '0;
      gen_q       <= '0;
      ovf_q       <= 1'b0;
      div_start_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      div_start_q <= 1'b0;
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_CLEAR: begin
          if (p_q == HIST_LAST) begin
            p_q     <= '0;
            state_q <= ST_LOAD;
          end else begin
            p_q <= p_q + HIST_AW'(1);
          end
        end
        ST_LOAD: begin
          if (in_acc) begin
            if (store) begin
              stored_q <= stored_q + CW'(1);
              if (genuine_i) begin
                gen_q <= gen_q + CW'(1);
              end
            end else begin
              ovf_q <= 1'b1;
            end
            if (last_item_i) begin
              state_q <= ST_DRAIN;
            end
          end
        end
        ST_DRAIN: begin
          p_q     <= '0;
          state_q <= ST_SWEEP;
        end
        ST_SWEEP: begin
          if (p_q == HIST_LAST) begin
            p_q     <= '0;
            state_q <= ST_FLUSH;
          end else begin
            p_q <= p_q + HIST_AW'(1);
          end
        end
        ST_FLUSH: begin
          if (!sw1_valid_q && !ev_q && !trk_busy) begin
            div_start_q <= 1'b1;
            state_q     <= ST_DIV_FAR;
          end
        end
        ST_DIV_FAR: begin
          if (div_done) begin
            div_start_q <= 1'b1;
            state_q     <= ST_DIV_FRR;
          end
        end
        ST_DIV_FRR: begin
          if (div_done) begin
            div_start_q <= 1'b1;
            state_q     <= ST_DIV_EER;
          end
        end
        ST_DIV_EER: begin
          if (div_done) begin
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit) begin
            out_valid_q <= 1'b1;
            stored_q    <= '0;
            gen_q       <= '0;
            ovf_q       <= 1'b0;
            state_q     <= ST_LOAD;
          end
        end
        default: state_q <= ST_CLEAR;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_done) begin
      unique case (state_q)
        ST_DIV_FAR: far_q <= div_quot;
        ST_DIV_FRR: frr_q <= div_quot;
        ST_DIV_EER: eer_q <= div_quot;
        default:    ;
      endcase
    end
    if (emit) begin
      res_eer_q <= OUT_W'(eer_q);
      res_far_q <= OUT_W'(far_q);
      res_frr_q <= OUT_W'(frr_q);
      res_t_q   <= best_t;
      res_gen_q <= TOTAL_W'(gen_q);
      res_imp_q <= TOTAL_W'(imp_cnt);
      res_ovf_q <= ovf_q;
    end
  end

  assign out_valid_o            = out_valid_q;
  assign eer_q16_o              = res_eer_q;
  assign best_threshold_milli_o = res_t_q;
  assign far_q16_o              = res_far_q;
  assign frr_q16_o              = res_frr_q;
  assign genuine_total_o        = res_gen_q;
  assign impostor_total_o       = res_imp_q;
  assign overflowed_o           = res_ovf_q;

endmodule

>>> design/eers_checker.sv
module eers_checker #(
  parameter int MAX_SCORES         = eers_pkg::MAX_SCORES_DEF,
  parameter int RATE_FRACTION_BITS = eers_pkg::RATE_FRAC_DEF
) (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_o,
  input logic                                last_item_i,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic [eers_pkg::OUT_W-1:0]          eer_q16_o,
  input logic [eers_pkg::THR_W-1:0]          best_threshold_milli_o,
  input logic [eers_pkg::OUT_W-1:0]          far_q16_o,
  input logic [eers_pkg::OUT_W-1:0]          frr_q16_o,
  input logic [eers_pkg::TOTAL_W-1:0]        genuine_total_o,
  input logic [eers_pkg::TOTAL_W-1:0]        impostor_total_o,
  input logic                                overflowed_o
);

  import eers_pkg::*;

  logic [OUT_W+1:0]   twice_eer, rate_sum;
  logic [TOTAL_W:0]   total_sum;

  assign twice_eer = {1'b0, eer_q16_o, 1'b0};
  assign rate_sum  = (OUT_W + 2)'(far_q16_o) + (OUT_W + 2)'(frr_q16_o);
  assign total_sum = (TOTAL_W + 1)'(genuine_total_o) + (TOTAL_W + 1)'(impostor_total_o);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(eer_q16_o) &&
      $stable(best_threshold_milli_o) && $stable(far_q16_o) && $stable(frr_q16_o) &&
      $stable(genuine_total_o) && $stable(impostor_total_o) && $stable(overflowed_o))
    else $error("result changed while stalled");

  // the last word of a set closes the input until the set's result is emitted
  a_last_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && last_item_i |=> !in_ready_o)
    else $error("input still open after last word");

  a_result_after_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared while loading");

  // mean of the two rates, each rounded once
  a_eer_mean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (RATE_FRACTION_BITS <= 16) |->
      (twice_eer <= rate_sum + (OUT_W + 2)'(2)) && (rate_sum <= twice_eer + (OUT_W + 2)'(2)))
    else $error("eer is not the mean of far and frr");

  a_overflow_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflowed_o && (MAX_SCORES <= 1024) |->
      total_sum == (TOTAL_W + 1)'(MAX_SCORES))
    else $error("overflow flagged with store not full");

endmodule

bind equal_error_rate_sweep eers_checker #(
  .MAX_SCORES         (MAX_SCORES),
  .RATE_FRACTION_BITS (RATE_FRACTION_BITS)
) u_eers_checker (.*);

>>> test/tb_top.sv
import eers_pkg::*;

localparam int SCORE_FLOOR = -1;
localparam int SCORE_CEIL  = 100001;

typedef struct {
  logic [OUT_W-1:0]   eer;
  logic [THR_W-1:0]   thr;
  logic [OUT_W-1:0]   far;
  logic [OUT_W-1:0]   frr;
  logic [TOTAL_W-1:0] gen_total;
  logic [TOTAL_W-1:0] imp_total;
  logic               overflow;
} eer_result_t;

class eer_tracker;
  logic [THR_W-1:0] step_reg;
  logic [THR_W-1:0] max_reg;
  int               set_scores[$];
  bit               set_genuine[$];
  int               genuine_n;
  bit               dropped;
  int unsigned      hist_gen[HIST_DEPTH];
  int unsigned      hist_imp[HIST_DEPTH];
  eer_result_t      pending_eers[$];
  int               errors;

  function new();
    step_reg  = STEP_RESET;
    max_reg   = THRESH_CAP;
    genuine_n = 0;
    dropped   = 1'b0;
    errors    = 0;
  endfunction

  function int pending();
    return pending_eers.size();
  endfunction

  function void write_reg(cfg_idx_e idx, logic [THR_W-1:0] data);
    case (idx)
      CFG_STEP: step_reg = data;
      CFG_MAX:  max_reg = data;
      default: ;
    endcase
  endfunction

  // fraction scaled by 2^frac, rounded half up; empty denominator gives 0
  function longint unsigned rate_q(longint unsigned num, longint unsigned den);
    if (den == 0) return 0;
    return ((num << RATE_FRAC_DEF) + den / 2) / den;
  endfunction

  function eer_result_t sweep_thresholds();
    int              step_v, tmax_v, t, pos, gen_n, imp_n, best_t;
    longint unsigned gen_d, imp_d, below_imp, below_gen;
    longint unsigned fa, fr, a, b, diff, best_diff, best_fa, best_fr;
    bit              have;
    eer_result_t     r;
    gen_n  = genuine_n;
    imp_n  = set_scores.size() - genuine_n;
    gen_d  = (gen_n != 0) ? longint'(gen_n) : 1;
    imp_d  = (imp_n != 0) ? longint'(imp_n) : 1;
    step_v = (step_reg != 0) ? int'(step_reg) : 1;
    tmax_v = (max_reg > THRESH_CAP) ? int'(THRESH_CAP) : int'(max_reg);
    foreach (set_scores[i]) begin
      if (set_genuine[i]) hist_gen[set_scores[i] - SCORE_FLOOR]++;
      else hist_imp[set_scores[i] - SCORE_FLOOR]++;
    end
    pos = 0;
    below_imp = 0;
    below_gen = 0;
    have = 1'b0;
    best_diff = 0;
    best_fa = 0;
    best_fr = 0;
    best_t = 0;
    for (t = 0; t <= tmax_v; t += step_v) begin
      // advance over every score value below t
      while (pos < HIST_DEPTH && pos + SCORE_FLOOR < t) begin
        below_imp += hist_imp[pos];
        below_gen += hist_gen[pos];
        pos++;
      end
      fa = (imp_n != 0) ? longint'(imp_n) - below_imp : 0;
      fr = (gen_n != 0) ? below_gen : 0;
      a = fa * gen_d;
      b = fr * imp_d;
      diff = (a > b) ? a - b : b - a;
      if (!have || diff < best_diff) begin
        have = 1'b1;
        best_diff = diff;
        best_t = t;
        best_fa = fa;
        best_fr = fr;
      end
    end
    r.eer       = OUT_W'(rate_q(best_fa * gen_d + best_fr * imp_d, 2 * imp_d * gen_d));
    r.thr       = THR_W'(best_t);
    r.far       = OUT_W'(rate_q(best_fa, longint'(imp_n)));
    r.frr       = OUT_W'(rate_q(best_fr, longint'(gen_n)));
    r.gen_total = TOTAL_W'(gen_n);
    r.imp_total = TOTAL_W'(imp_n);
    r.overflow  = dropped;
    foreach (set_scores[i]) begin
      hist_gen[set_scores[i] - SCORE_FLOOR] = 0;
      hist_imp[set_scores[i] - SCORE_FLOOR] = 0;
    end
    return r;
  endfunction

  function void note_word(logic signed [SCORE_W-1:0] score, bit genuine, bit last);
    int s;
    s = score;
    if (s < SCORE_FLOOR) s = SCORE_FLOOR;
    if (s > SCORE_CEIL) s = SCORE_CEIL;
    if (set_scores.size() < MAX_SCORES_DEF) begin
      set_scores.push_back(s);
      set_genuine.push_back(genuine);
      if (genuine) genuine_n++;
    end else begin
      dropped = 1'b1;
    end
    if (last) begin
      pending_eers.push_back(sweep_thresholds());
      set_scores.delete();
      set_genuine.delete();
      genuine_n = 0;
      dropped = 1'b0;
    end
  endfunction

  function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      errors++;
    end
  endfunction

  function void check_result(eer_result_t got);
    eer_result_t exp_r;
    if (pending_eers.size() == 0) begin
      $error("result word with no expected result waiting");
      errors++;
      return;
    end
    exp_r = pending_eers.pop_front();
    compare_field("eer_q16", 32'(exp_r.eer), 32'(got.eer));
    compare_field("best_threshold_milli", 32'(exp_r.thr), 32'(got.thr));
    compare_field("far_q16", 32'(exp_r.far), 32'(got.far));
    compare_field("frr_q16", 32'(exp_r.frr), 32'(got.frr));
    compare_field("genuine_total", 32'(exp_r.gen_total), 32'(got.gen_total));
    compare_field("impostor_total", 32'(exp_r.imp_total), 32'(got.imp_total));
    compare_field("overflowed", 32'(exp_r.overflow), 32'(got.overflow));
  endfunction
endclass

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 1000000;
  localparam int PRESSURE_HOLD  = 250000;
  localparam int SETTLE_CYCLES  = 32;
  localparam int MAX_GAP        = 200;

  logic                      clk;
  logic                      rst_n     = 1'b0;
  logic                      in_valid  = 1'b0;
  logic signed [SCORE_W-1:0] score     = '0;
  logic                      genuine   = 1'b0;
  logic                      last_item = 1'b0;
  logic                      cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [THR_W-1:0]          cfg_data  = '0;
  logic                      out_ready = 1'b0;

  logic               in_ready_o, cfg_ready_o, out_valid_o, overflowed_o;
  logic [OUT_W-1:0]   eer_q16_o, far_q16_o, frr_q16_o;
  logic [THR_W-1:0]   best_threshold_milli_o;
  logic [TOTAL_W-1:0] genuine_total_o, impostor_total_o;

  eer_tracker tracker = new();

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_request   = 0;

  equal_error_rate_sweep uut (
    .clk_i                  (clk),
    .rst_ni                 (rst_n),
    .in_valid_i             (in_valid),
    .in_ready_o             (in_ready_o),
    .score_milli_i          (score),
    .genuine_i              (genuine),
    .last_item_i            (last_item),
    .cfg_valid_i            (cfg_valid),
    .cfg_ready_o            (cfg_ready_o),
    .cfg_index_i            (cfg_index),
    .cfg_data_i             (cfg_data),
    .out_valid_o            (out_valid_o),
    .out_ready_i            (out_ready),
    .eer_q16_o              (eer_q16_o),
    .best_threshold_milli_o (best_threshold_milli_o),
    .far_q16_o              (far_q16_o),
    .frr_q16_o              (frr_q16_o),
    .genuine_total_o        (genuine_total_o),
    .impostor_total_o       (impostor_total_o),
    .overflowed_o           (overflowed_o)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // result side: check accepted words, stall at random or hold off on request
  initial begin
    eer_result_t got;
    int          hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (out_valid_o && out_ready) begin
        got.eer       = eer_q16_o;
        got.thr       = best_threshold_milli_o;
        got.far       = far_q16_o;
        got.frr       = frr_q16_o;
        got.gen_total = genuine_total_o;
        got.imp_total = impostor_total_o;
        got.overflow  = overflowed_o;
        tracker.check_result(got);
      end
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready_o) || (cfg_valid && cfg_ready_o) || (out_valid_o && out_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  function int idle_gap();
    int g;
    g = 0;
    while (g < MAX_GAP && $urandom_range(99) < send_idle_pct) g++;
    return g;
  endfunction

  task automatic send_word(input int s, input bit g, input bit l);
    logic signed [SCORE_W-1:0] v;
    int                        gap;
    v = SCORE_W'(s);
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    score     <= v;
    genuine   <= g;
    last_item <= l;
    @(posedge clk);
    while (!in_ready_o) @(posedge clk);
    tracker.note_word(v, g, l);
  endtask

  task automatic cfg_write(input cfg_idx_e idx, input logic [THR_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready_o) @(posedge clk);
    tracker.write_reg(idx, d);
  endtask

  task automatic configure(input int step_v, input int max_v);
    cfg_write(CFG_STEP, THR_W'(step_v));
    cfg_write(CFG_MAX, THR_W'(max_v));
    cfg_valid <= 1'b0;
  endtask

  // hold the input, wait for every result, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure_random();
    int step_v, max_v;
    case ($urandom_range(9))
      0: step_v = 0;
      1: step_v = 1;
      2: step_v = (1 << THR_W) - 1;
      3: step_v = 100000;
      default: step_v = int'($urandom_range(5000, 1));
    endcase
    case ($urandom_range(9))
      0: max_v = 0;
      1: max_v = (1 << THR_W) - 1;
      2, 3, 4: max_v = 100000;
      default: max_v = int'($urandom_range(100000, 0));
    endcase
    configure(step_v, max_v);
  endtask

  function int draw_score(bit g);
    int edge_vals[8];
    int r;
    edge_vals = '{-1, 0, 100000, 100001, -2, 100002, -1048576, 1048575};
    r = int'($urandom_range(99));
    if (r < 8) return int'($urandom_range(2097151)) - 1048576;
    if (r < 14) return edge_vals[$urandom_range(7)];
    if (g) return int'($urandom_range(100001, 30000));
    return int'($urandom_range(70000, 0));
  endfunction

  task automatic fill_set(input int len);
    int gen_pct;
    bit g;
    case ($urandom_range(7))
      0: gen_pct = 0;
      1: gen_pct = 100;
      default: gen_pct = int'($urandom_range(90, 10));
    endcase
    for (int i = 0; i < len; i++) begin
      g = ($urandom_range(99) < gen_pct);
      send_word(draw_score(g), g, i == len - 1);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // extremes of the score field at the reset settings
    send_word(-1048576, 1'b0, 1'b0);
    send_word(1048575, 1'b1, 1'b0);
    send_word(-1, 1'b0, 1'b0);
    send_word(0, 1'b1, 1'b0);
    send_word(100001, 1'b0, 1'b0);
    send_word(100000, 1'b1, 1'b0);
    send_word(-2, 1'b1, 1'b0);
    send_word(100002, 1'b0, 1'b0);
    send_word(50000, 1'b1, 1'b0);
    send_word(50000, 1'b0, 1'b1);
    drain();
    // zero step, maximum above range, no impostors
    configure(0, (1 << THR_W) - 1);
    send_word(60000, 1'b1, 1'b0);
    send_word(70000, 1'b1, 1'b1);
    drain();
    // step above maximum, no genuine scores
    configure((1 << THR_W) - 1, 100000);
    send_word(10, 1'b0, 1'b0);
    send_word(90000, 1'b0, 1'b1);
    drain();
    // only threshold zero
    configure(100000, 0);
    send_word(-5, 1'b1, 1'b0);
    send_word(3, 1'b0, 1'b0);
    send_word(0, 1'b1, 1'b1);
    drain();
    // scores on and just below the thresholds
    configure(25000, 100000);
    send_word(25000, 1'b1, 1'b0);
    send_word(25000, 1'b0, 1'b0);
    send_word(74999, 1'b1, 1'b0);
    send_word(75000, 1'b0, 1'b1);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      for (int k = 0; k < 6; k++) begin
        drain();
        configure_random();
        fill_set(int'($urandom_range(10, 1)));
      end
      if (phase == 0) begin
        // overfill the store; the last word is dropped but still starts the sweep
        drain();
        configure_random();
        fill_set(MAX_SCORES_DEF + 2);
        // hold off results while sets keep coming, so the input backs up
        drain();
        configure_random();
        hold_request = PRESSURE_HOLD;
        for (int k = 0; k < 3; k++) fill_set(int'($urandom_range(30, 5)));
      end
    end

    drain();
    repeat (200) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end
endmodule

>>> filelist.f
design/eers_pkg.sv
design/eers_hist_ram.sv
design/eers_divider.sv
design/eers_best_track.sv
design/equal_error_rate_sweep.sv
design/eers_checker.sv
test/tb_top.sv
